[hw/rtl/scr_pkg.sv]
// ----------------------------------------------------------------------------
// scr_pkg: shared types, constants and the sRGB curve table
// Widths, WCAG weights and the elaboration-time build of the 256-entry
// sRGB-to-linear table used by the contrast ratio pipeline.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int LUMA_FRACTION_BITS  = 16;
  localparam int RATIO_FRACTION_BITS = 12;

  localparam int COLOUR_W = 24;
  localparam int CHAN_W   = 8;
  localparam int LUMA_W   = LUMA_FRACTION_BITS;
  localparam int CURVE_W  = LUMA_W + 1;
  localparam int RATIO_W  = RATIO_FRACTION_BITS + 5;

  localparam int LSUM_W       = LUMA_W + 14;
  localparam int LUMA_DIVISOR = 10000;
  localparam int RECIP_SHIFT  = LSUM_W + 14;
  localparam int RECIP_W      = RECIP_SHIFT - 13;
  localparam int PROD_W       = LSUM_W + RECIP_W;

  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(LUMA_DIVISOR) - 64'd1) / 64'(LUMA_DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_FULL);

  localparam logic [LSUM_W-1:0] WEIGHT_RED   = LSUM_W'(2126);
  localparam logic [LSUM_W-1:0] WEIGHT_GREEN = LSUM_W'(7152);
  localparam logic [LSUM_W-1:0] WEIGHT_BLUE  = LSUM_W'(722);
  localparam logic [LSUM_W-1:0] LUMA_ROUND   = LSUM_W'(LUMA_DIVISOR / 2);
  localparam logic [LUMA_W-1:0] LUMA_MAX     = '1;

  localparam int DEN_W          = LUMA_W + 5;
  localparam int NUM_W          = LUMA_W + RATIO_FRACTION_BITS + 6;
  localparam int QUO_MIN_W      = RATIO_FRACTION_BITS + 6;
  localparam int DIV_STEP_BITS  = 3;
  localparam int DIV_STAGES     = (QUO_MIN_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int DIV_Q_W        = DIV_STAGES * DIV_STEP_BITS;

  localparam logic [DEN_W-1:0] CONTRAST_SCALE = DEN_W'(20);
  localparam logic [DEN_W-1:0] LUMA_ONE       = DEN_W'(2 ** LUMA_FRACTION_BITS);

  localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(2 ** RATIO_FRACTION_BITS);
  localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(21 * (2 ** RATIO_FRACTION_BITS));

  typedef struct packed {
    logic [LUMA_W-1:0] luma_a;
    logic [LUMA_W-1:0] luma_b;
  } luma_pair_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    luma_pair_t       luma;
    logic             first_lighter;
  } div_req_t;

  typedef struct packed {
    luma_pair_t         luma;
    logic [RATIO_W-1:0] ratio;
    logic               first_lighter;
  } result_t;

  localparam int WIDE_W       = 320;
  localparam int CURVE_DEN    = 10761;
  localparam int LINEAR_LIMIT = 10;
  localparam longint unsigned LINEAR_DIV = 64'd32946;

  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [255:0][CURVE_W-1:0] curve_table_t;

  // Linear segment uses round(c / (255 * 12.92)); the power segment finds
  // the largest y with (2y - 1)^5 * 10761^12 <= (40c + 561)^12 * 2^(5(F+1)).
  function automatic logic [CURVE_W-1:0] curve_entry(int unsigned c);
    wide_t den12;
    wide_t rhs;
    wide_t lhs;
    wide_t base;
    logic [CURVE_W:0] lo;
    logic [CURVE_W:0] hi;
    logic [CURVE_W:0] mid;
    logic [63:0] lin;
    den12 = wide_t'(1);
    for (int k = 0; k < 12; k++) begin
      den12 = den12 * wide_t'(CURVE_DEN);
    end
    if (c <= LINEAR_LIMIT) begin
      lin = ((64'(c) * 64'd10) << LUMA_FRACTION_BITS) + (LINEAR_DIV / 64'd2);
      return CURVE_W'(lin / LINEAR_DIV);
    end
    base = wide_t'(40 * c + 561);
    rhs = wide_t'(1);
    for (int k = 0; k < 12; k++) begin
      rhs = rhs * base;
    end
    rhs = rhs << (5 * (LUMA_FRACTION_BITS + 1));
    lo = (CURVE_W + 1)'(1);
    hi = ((CURVE_W + 1)'(1) << LUMA_FRACTION_BITS) + (CURVE_W + 1)'(1);
    for (int it = 0; it < CURVE_W + 1; it++) begin
      if (hi - lo > (CURVE_W + 1)'(1)) begin
        mid = lo + ((hi - lo) >> 1);
        lhs = den12;
        for (int k = 0; k < 5; k++) begin
          lhs = lhs * (wide_t'(mid) * wide_t'(2) - wide_t'(1));
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
    return lo[CURVE_W-1:0];
  endfunction

  function automatic curve_table_t build_curve();
    curve_table_t t;
    for (int unsigned c = 0; c < 256; c++) begin
      t[c] = curve_entry(c);
    end
    return t;
  endfunction

  localparam curve_table_t CURVE = build_curve();

endpackage

[hw/rtl/scr_luma.sv]
// ----------------------------------------------------------------------------
// scr_luma: relative luminance pipeline
// Four stages: curve lookup, weighted channel sum, reciprocal multiply for
// the division by 10000, then quotient extraction with saturation.
// ----------------------------------------------------------------------------
module scr_luma
  import scr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COLOUR_W-1:0] colour_a,
  input  logic [COLOUR_W-1:0] colour_b,
  output logic                out_valid,
  input  logic                out_ready,
  output luma_pair_t          out_luma
);

  typedef logic [CURVE_W-1:0] lin_t;

  lin_t              lin_a [3];
  lin_t              lin_b [3];
  logic [LSUM_W-1:0] sum_a;
  logic [LSUM_W-1:0] sum_b;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  luma_pair_t        luma;
  logic [3:0]        valid;
  logic [3:0]        en;

  function automatic logic [LSUM_W-1:0] weigh(lin_t r, lin_t g, lin_t b);
    return LSUM_W'(r) * WEIGHT_RED + LSUM_W'(g) * WEIGHT_GREEN
         + LSUM_W'(b) * WEIGHT_BLUE + LUMA_ROUND;
  endfunction

  function automatic logic [LUMA_W-1:0] saturate(logic [PROD_W-1:0] p);
    logic [CURVE_W-1:0] q;
    q = p[PROD_W-1 -: CURVE_W];
    return q[LUMA_W] ? LUMA_MAX : q[LUMA_W-1:0];
  endfunction

  assign en[3] = !valid[3] || out_ready;
  assign en[2] = !valid[2] || en[3];
  assign en[1] = !valid[1] || en[2];
  assign en[0] = !valid[0] || en[1];

  assign in_ready  = en[0];
  assign out_valid = valid[3];
  assign out_luma  = luma;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      if (en[1]) valid[1] <= valid[0];
      if (en[2]) valid[2] <= valid[1];
      if (en[3]) valid[3] <= valid[2];
    end
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        lin_a[i] <= CURVE[colour_a[CHAN_W*i +: CHAN_W]];
        lin_b[i] <= CURVE[colour_b[CHAN_W*i +: CHAN_W]];
      end
    end
    if (en[1]) begin
      sum_a <= weigh(lin_a[0], lin_a[1], lin_a[2]);
      sum_b <= weigh(lin_b[0], lin_b[1], lin_b[2]);
    end
    if (en[2]) begin
      prod_a <= PROD_W'(sum_a) * PROD_W'(RECIP_MULT);
      prod_b <= PROD_W'(sum_b) * PROD_W'(RECIP_MULT);
    end
    if (en[3]) begin
      luma.luma_a <= saturate(prod_a);
      luma.luma_b <= saturate(prod_b);
    end
  end

endmodule

[hw/rtl/scr_prep.sv]
// ----------------------------------------------------------------------------
// scr_prep: ratio operand stage
// Orders the two luminances and forms the rounded numerator and the
// denominator of (lighter + 0.05) / (darker + 0.05) in fixed point.
// ----------------------------------------------------------------------------
module scr_prep
  import scr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  luma_pair_t in_luma,
  output logic       out_valid,
  input  logic       out_ready,
  output div_req_t   out_req
);

  logic              valid;
  div_req_t          req;
  div_req_t          req_next;
  logic              first;
  logic [LUMA_W-1:0] lum_hi;
  logic [LUMA_W-1:0] lum_lo;
  logic [DEN_W-1:0]  num_base;
  logic [DEN_W-1:0]  den;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_req   = req;

  always_comb begin
    first    = in_luma.luma_a >= in_luma.luma_b;
    lum_hi   = first ? in_luma.luma_a : in_luma.luma_b;
    lum_lo   = first ? in_luma.luma_b : in_luma.luma_a;
    num_base = DEN_W'(lum_hi) * CONTRAST_SCALE + LUMA_ONE;
    den      = DEN_W'(lum_lo) * CONTRAST_SCALE + LUMA_ONE;
    req_next.num           = (NUM_W'(num_base) << RATIO_FRACTION_BITS) + NUM_W'(den >> 1);
    req_next.den           = den;
    req_next.luma          = in_luma;
    req_next.first_lighter = first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready) begin
      req <= req_next;
    end
  end

endmodule

[hw/rtl/scr_divider.sv]
// ----------------------------------------------------------------------------
// scr_divider: pipelined restoring divider with range clamp
// Each stage resolves three quotient bits; a final register clamps the
// quotient to the contrast ratio range and holds the result.
// ----------------------------------------------------------------------------
module scr_divider
  import scr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_result
);

  typedef struct packed {
    logic [DEN_W-1:0]   rem;
    logic [DIV_Q_W-1:0] nlo;
    logic [DIV_Q_W-1:0] quo;
    logic [DEN_W-1:0]   den;
    luma_pair_t         luma;
    logic               first_lighter;
  } div_stage_t;

  div_stage_t            head;
  div_stage_t            pipe [DIV_STAGES];
  logic [DIV_STAGES-1:0] valid;
  logic [DIV_STAGES-1:0] en;
  logic                  out_en;
  logic                  res_valid;
  result_t               result;
  logic [DIV_Q_W-1:0]    quo_last;
  logic [RATIO_W-1:0]    ratio_clamped;

  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t       o;
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] r;
    o = s;
    r = s.rem;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      t = {r, o.nlo[DIV_Q_W-1]};
      o.nlo = o.nlo << 1;
      o.quo = o.quo << 1;
      if (t >= {1'b0, s.den}) begin
        t = t - {1'b0, s.den};
        o.quo[0] = 1'b1;
      end
      r = t[DEN_W-1:0];
    end
    o.rem = r;
    return o;
  endfunction

  always_comb begin
    head.rem           = DEN_W'(in_req.num >> DIV_Q_W);
    head.nlo           = in_req.num[DIV_Q_W-1:0];
    head.quo           = '0;
    head.den           = in_req.den;
    head.luma          = in_req.luma;
    head.first_lighter = in_req.first_lighter;
  end

  assign out_en   = !res_valid || out_ready;
  assign in_ready = en[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_stage_t src;
    div_stage_t nxt;
    logic       src_valid;
    logic       down_en;
    if (k == 0) begin : g_head
      assign src       = head;
      assign src_valid = in_valid;
    end else begin : g_body
      assign src       = pipe[k-1];
      assign src_valid = valid[k-1];
    end
    if (k == DIV_STAGES - 1) begin : g_tail
      assign down_en = out_en;
    end else begin : g_mid
      assign down_en = en[k+1];
    end
    assign en[k] = !valid[k] || down_en;
    assign nxt   = div_step(src);
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en[k]) begin
        valid[k] <= src_valid;
      end
      if (en[k]) begin
        pipe[k] <= nxt;
      end
    end
  end

  always_comb begin
    quo_last = pipe[DIV_STAGES-1].quo;
    if (quo_last < DIV_Q_W'(RATIO_MIN)) begin
      ratio_clamped = RATIO_MIN;
    end else if (quo_last > DIV_Q_W'(RATIO_MAX)) begin
      ratio_clamped = RATIO_MAX;
    end else begin
      ratio_clamped = quo_last[RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_en) begin
      res_valid <= valid[DIV_STAGES-1];
    end
    if (out_en) begin
      result.luma          <= pipe[DIV_STAGES-1].luma;
      result.ratio         <= ratio_clamped;
      result.first_lighter <= pipe[DIV_STAGES-1].first_lighter;
    end
  end

  assign out_valid  = res_valid;
  assign out_result = result;

endmodule

[hw/rtl/srgb_contrast_ratio.sv]
// ----------------------------------------------------------------------------
// srgb_contrast_ratio: WCAG 2.x contrast ratio of two packed sRGB colours
// Path: luma stages, prep register, divider stages, then the result register.
// Throughput: one request per cycle; each register stage holds while its
// successor is stalled, so bubbles fill even when the output is blocked.
// Reset clears every stage valid bit; the curve table is a constant.
// ----------------------------------------------------------------------------
module srgb_contrast_ratio
  import scr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                colour_valid,
  output logic                colour_ready,
  input  logic [COLOUR_W-1:0] colour_a,
  input  logic [COLOUR_W-1:0] colour_b,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [LUMA_W-1:0]   luminance_a,
  output logic [LUMA_W-1:0]   luminance_b,
  output logic [RATIO_W-1:0]  ratio,
  output logic                first_is_lighter
);

  logic       luma_valid;
  logic       luma_ready;
  luma_pair_t luma;
  logic       req_valid;
  logic       req_ready;
  div_req_t   req;
  result_t    result;

  scr_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (colour_valid),
    .in_ready  (colour_ready),
    .colour_a  (colour_a),
    .colour_b  (colour_b),
    .out_valid (luma_valid),
    .out_ready (luma_ready),
    .out_luma  (luma)
  );

  scr_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (luma_valid),
    .in_ready  (luma_ready),
    .in_luma   (luma),
    .out_valid (req_valid),
    .out_ready (req_ready),
    .out_req   (req)
  );

  scr_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req_valid),
    .in_ready   (req_ready),
    .in_req     (req),
    .out_valid  (result_valid),
    .out_ready  (result_ready),
    .out_result (result)
  );

  assign luminance_a      = result.luma.luma_a;
  assign luminance_b      = result.luma.luma_b;
  assign ratio            = result.ratio;
  assign first_is_lighter = result.first_lighter;

endmodule

[hw/rtl/scr_checker.sv]
// ----------------------------------------------------------------------------
// scr_checker: port-level checks for srgb_contrast_ratio
// Watches the result channel for range, ordering, unity ratio, stall and reset.
// ----------------------------------------------------------------------------
module scr_checker
  import scr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic [LUMA_W-1:0]   luminance_a,
  input logic [LUMA_W-1:0]   luminance_b,
  input logic [RATIO_W-1:0]  ratio,
  input logic                first_is_lighter
);

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (ratio >= RATIO_MIN) && (ratio <= RATIO_MAX))
    else $error("ratio outside contrast range");

  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> first_is_lighter == (luminance_a >= luminance_b))
    else $error("first_is_lighter disagrees with luminances");

  a_equal_unity: assert property (@(posedge clk) disable iff (rst)
    result_valid && (luminance_a == luminance_b) |-> ratio == RATIO_MIN)
    else $error("equal luminances must give a ratio of one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable({luminance_a, luminance_b, ratio, first_is_lighter}))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind srgb_contrast_ratio scr_checker u_scr_checker (.*);

[verif/contrast_checker.sv]
// ----------------------------------------------------------------------------
// contrast_checker: result checker for the sRGB contrast ratio pipeline
// Watches the request and result channels, predicts the luminances, the lighter flag
// and the clamped Q5.12 contrast ratio of every accepted request from its
// own copy of the sRGB curve, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module contrast_checker
  import scr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                colour_valid,
  input  logic                colour_ready,
  input  logic [COLOUR_W-1:0] colour_a,
  input  logic [COLOUR_W-1:0] colour_b,
  input  logic                result_valid,
  input  logic                result_ready,
  input  logic [LUMA_W-1:0]   luminance_a,
  input  logic [LUMA_W-1:0]   luminance_b,
  input  logic [RATIO_W-1:0]  ratio,
  input  logic                first_is_lighter,
  output int                  failures,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned    LINEAR_TOP   = 10;
  localparam longint unsigned LINEAR_SCALE = 64'd32946;
  localparam int unsigned    GAMMA_DEN    = 10761;
  localparam int unsigned    LUMA_UNITY   = 1 << LUMA_FRACTION_BITS;

  typedef struct packed {
    logic [LUMA_W-1:0]  luma_a;
    logic [LUMA_W-1:0]  luma_b;
    logic [RATIO_W-1:0] ratio;
    logic               lighter_first;
  } contrast_t;

  logic [CURVE_W-1:0] srgb_to_linear [256];
  contrast_t          pending_contrast [$];
  int                 mismatch_count = 0;
  int                 in_flight = 0;

  assign failures    = mismatch_count;
  assign outstanding = in_flight;

  // True when (2y - 1)^5 * 10761^12 <= (40c + 561)^12 * 2^(5(F+1)).
  function automatic bit power_fits(int unsigned c, int unsigned y);
    logic [319:0] lhs;
    logic [319:0] rhs;
    lhs = 320'd1;
    rhs = 320'd1;
    for (int k = 0; k < 12; k++) begin
      lhs = lhs * 320'(GAMMA_DEN);
      rhs = rhs * 320'(40 * c + 561);
    end
    for (int k = 0; k < 5; k++) begin
      lhs = lhs * 320'(2 * y - 1);
    end
    rhs = rhs << (5 * (LUMA_FRACTION_BITS + 1));
    return lhs <= rhs;
  endfunction

  // Linear segment in integers; the power segment from a floating-point estimate, settled exactly.
  function automatic logic [CURVE_W-1:0] linearize(int unsigned c);
    real         t;
    int unsigned y;
    if (c <= LINEAR_TOP) begin
      return CURVE_W'(((64'(c) * 64'd10 << LUMA_FRACTION_BITS) + LINEAR_SCALE / 64'd2)
                      / LINEAR_SCALE);
    end
    t = real'(40 * c + 561) / real'(GAMMA_DEN);
    y = $rtoi(real'(LUMA_UNITY) * $pow(t, 2.4) + 0.5);
    if (y < 1) y = 1;
    if (y > LUMA_UNITY) y = LUMA_UNITY;
    while (y < LUMA_UNITY && power_fits(c, y + 1)) y++;
    while (y > 1 && !power_fits(c, y)) y--;
    return CURVE_W'(y);
  endfunction

  function automatic logic [LUMA_W-1:0] relative_luminance(logic [COLOUR_W-1:0] colour);
    longint unsigned s;
    s = (64'd2126 * srgb_to_linear[colour[7:0]] + 64'd7152 * srgb_to_linear[colour[15:8]]
         + 64'd722 * srgb_to_linear[colour[23:16]] + 64'd5000) / 64'd10000;
    if (s > 64'(LUMA_MAX)) s = 64'(LUMA_MAX);
    return LUMA_W'(s);
  endfunction

  function automatic contrast_t predict_contrast(logic [COLOUR_W-1:0] a,
                                                 logic [COLOUR_W-1:0] b);
    contrast_t       r;
    longint unsigned lh;
    longint unsigned ld;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    r.luma_a        = relative_luminance(a);
    r.luma_b        = relative_luminance(b);
    r.lighter_first = r.luma_a >= r.luma_b;
    lh  = r.lighter_first ? r.luma_a : r.luma_b;
    ld  = r.lighter_first ? r.luma_b : r.luma_a;
    num = (64'd20 * lh + 64'(LUMA_UNITY)) << RATIO_FRACTION_BITS;
    den = 64'd20 * ld + 64'(LUMA_UNITY);
    q   = (num + den / 64'd2) / den;
    if (q < 64'(RATIO_MIN)) q = 64'(RATIO_MIN);
    if (q > 64'(RATIO_MAX)) q = 64'(RATIO_MAX);
    r.ratio = RATIO_W'(q);
    return r;
  endfunction

  initial begin
    for (int unsigned c = 0; c < 256; c++) begin
      srgb_to_linear[c] = linearize(c);
    end
  end

  always @(posedge clk) begin
    contrast_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_contrast.size() == 0) begin
          $error("result with no request outstanding: luminance_a %0d ratio %0d",
                 luminance_a, ratio);
          mismatch_count++;
        end else begin
          want = pending_contrast.pop_front();
          if (luminance_a !== want.luma_a) begin
            $error("luminance_a: expected %0d, actual %0d", want.luma_a, luminance_a);
            mismatch_count++;
          end
          if (luminance_b !== want.luma_b) begin
            $error("luminance_b: expected %0d, actual %0d", want.luma_b, luminance_b);
            mismatch_count++;
          end
          if (ratio !== want.ratio) begin
            $error("ratio: expected %0d, actual %0d", want.ratio, ratio);
            mismatch_count++;
          end
          if (first_is_lighter !== want.lighter_first) begin
            $error("first_is_lighter: expected %0d, actual %0d",
                   want.lighter_first, first_is_lighter);
            mismatch_count++;
          end
        end
      end
      if (colour_valid && colour_ready) begin
        pending_contrast.push_back(predict_contrast(colour_a, colour_b));
      end
      in_flight = pending_contrast.size();
    end
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench top for srgb_contrast_ratio
// Drives directed corner colours and then random colour pairs with random
// idle bursts on both channels and one long output stall, and reports the
// verdict from the failure and outstanding counts of the attached checker.
// ----------------------------------------------------------------------------
module tb
  import scr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS    = 550;
  localparam int CALM_ITEMS      = 100;
  localparam int HOLD_OFF_AT     = 250;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 24;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                colour_valid = 1'b0;
  logic                colour_ready;
  logic [COLOUR_W-1:0] colour_a = '0;
  logic [COLOUR_W-1:0] colour_b = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [LUMA_W-1:0]   luminance_a;
  logic [LUMA_W-1:0]   luminance_b;
  logic [RATIO_W-1:0]  ratio;
  logic                first_is_lighter;
  int                  failures;
  int                  outstanding;
  int                  requests_taken = 0;
  bit                  calm = 1'b0;
  int                  quiet_cycles = 0;

  always #5 clk = ~clk;

  srgb_contrast_ratio DUT (
    .clk              (clk),
    .rst              (rst),
    .colour_valid     (colour_valid),
    .colour_ready     (colour_ready),
    .colour_a         (colour_a),
    .colour_b         (colour_b),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .luminance_a      (luminance_a),
    .luminance_b      (luminance_b),
    .ratio            (ratio),
    .first_is_lighter (first_is_lighter)
  );

  contrast_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .colour_valid     (colour_valid),
    .colour_ready     (colour_ready),
    .colour_a         (colour_a),
    .colour_b         (colour_b),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .luminance_a      (luminance_a),
    .luminance_b      (luminance_b),
    .ratio            (ratio),
    .first_is_lighter (first_is_lighter),
    .failures         (failures),
    .outstanding      (outstanding)
  );

  task automatic offer_pair(logic [COLOUR_W-1:0] a, logic [COLOUR_W-1:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      colour_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    colour_valid <= 1'b1;
    colour_a     <= a;
    colour_b     <= b;
    do @(posedge clk); while (!colour_ready);
    requests_taken++;
  endtask

  function automatic logic [7:0] corner_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd10;
      3: return 8'd11;
      4: return 8'd12;
      5: return 8'd254;
      6: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_pair(output logic [COLOUR_W-1:0] a, output logic [COLOUR_W-1:0] b);
    logic [7:0] g;
    a = COLOUR_W'($urandom);
    b = COLOUR_W'($urandom);
    case ($urandom_range(0, 9))
      5, 6: begin
        a = {corner_channel(), corner_channel(), corner_channel()};
        b = {corner_channel(), corner_channel(), corner_channel()};
      end
      7: b = a;
      8: b = a ^ (COLOUR_W'(1) << $urandom_range(0, COLOUR_W - 1));
      9: begin
        g = 8'($urandom);
        a = {g, g, g};
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [COLOUR_W-1:0] a;
    logic [COLOUR_W-1:0] b;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    offer_pair(24'h000000, 24'h000000);
    offer_pair(24'hFFFFFF, 24'h000000);
    offer_pair(24'h000000, 24'hFFFFFF);
    offer_pair(24'hFFFFFF, 24'hFFFFFF);
    offer_pair(24'hFFFFFF, 24'hFEFFFF);
    offer_pair(24'h0000FF, 24'h00FF00);
    offer_pair(24'hFF0000, 24'h0000FF);
    offer_pair(24'h00FF00, 24'hFF0000);
    offer_pair(24'h0A0A0A, 24'h0B0B0B);
    offer_pair(24'h0B0B0B, 24'h0A0A0A);
    offer_pair(24'h010101, 24'h000000);
    offer_pair(24'hAAAAAA, 24'h555555);
    offer_pair(24'h555555, 24'hAAAAAA);
    offer_pair(24'h808080, 24'h808080);
    offer_pair(24'h767676, 24'hFFFFFF);
    offer_pair(24'h000001, 24'h010000);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      random_pair(a, b);
      offer_pair(a, b);
    end
    @(negedge clk);
    colour_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("** srgb_contrast_ratio: PASSED **");
    end else begin
      $display("** srgb_contrast_ratio: FAILED **");
    end
    $finish;
  end

  // The long hold-off lets the pipeline fill so that the request side stalls.
  initial begin
    bit level;
    int span;
    bit held_off;
    held_off = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held_off && requests_taken >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        level    = 1'b0;
        span     = HOLD_OFF_CYCLES;
      end else if (calm) begin
        level = 1'b1;
        span  = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        level = 1'b0;
        span  = $urandom_range(1, 4);
      end else begin
        level = 1'b1;
        span  = $urandom_range(1, 6);
      end
      result_ready <= level;
      repeat (span) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((colour_valid && colour_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** srgb_contrast_ratio: FAILED **");
      $finish;
    end
  end

endmodule
